### hw/rtl/hsl2rgb_pkg.sv
`default_nettype none

package hsl2rgb_pkg;

   // field widths
   localparam int CHANNEL_BITS = 8;
   localparam int HUE_BITS     = 9;
   localparam int KX_BITS      = 6;

   // full-scale channel code and hue limits
   localparam int FULL_SCALE  = (1 << CHANNEL_BITS) - 1;
   localparam int HUE_MAX     = 359;
   localparam int SECTOR_SPAN = 60;
   localparam int HALF_SPAN   = 30;
   localparam int HUE_120     = 120;
   localparam int HUE_180     = 180;
   localparam int HUE_240     = 240;
   localparam int HUE_300     = 300;

   // 60-degree hue sectors
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW,
      SECTOR_YELLOW_GREEN,
      SECTOR_GREEN_CYAN,
      SECTOR_CYAN_BLUE,
      SECTOR_BLUE_MAGENTA,
      SECTOR_MAGENTA_RED
   } sector_type;

   // input item
   typedef struct packed {
      logic [HUE_BITS-1:0]     hue;
      logic [CHANNEL_BITS-1:0] saturation;
      logic [CHANNEL_BITS-1:0] lightness;
   } hsl_req_type;

   // result item
   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } hsl_rsp_type;

endpackage

`default_nettype wire

### hw/rtl/hsl_to_rgb_converter_unit.sv
// hsl to rgb pixel converter, fully pipelined over six register stages
// throughput: one item per cycle while rsp_stall does not hold a full pipeline;
// the depth is set by one stage each for hue and lightness terms, chroma, channel weights,
// biased sum, reciprocal quotient and the output clamp
// reset clears the stage valid bits only; data registers are not reset
`default_nettype none

module hsl_to_rgb_converter_unit (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire hsl2rgb_pkg::hsl_req_type req_item,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output hsl2rgb_pkg::hsl_rsp_type      rsp_item
);

   localparam int CB      = hsl2rgb_pkg::CHANNEL_BITS;
   localparam int HB      = hsl2rgb_pkg::HUE_BITS;
   localparam int KB      = hsl2rgb_pkg::KX_BITS;
   localparam int FULL    = hsl2rgb_pkg::FULL_SCALE;
   localparam int CW      = 2 * CB;
   localparam int ZW      = 2 * CB + 6;
   localparam int NSTAGE  = 6;
   localparam int ST_ZSUM = 3;
   localparam int ST_QUO  = 4;
   localparam int ST_OUT  = NSTAGE - 1;
   localparam int DIVISOR = hsl2rgb_pkg::SECTOR_SPAN * FULL;
   localparam int OFFSET  = (FULL - 1) / 2;
   // reciprocal of the divisor, exact for every sum up to ZMAX
   localparam int DB      = $clog2(DIVISOR);
   localparam int RSH     = ZW + DB;
   localparam int RW      = ZW + 1;
   localparam int PW      = RSH + CB;
   localparam longint unsigned RECIP_L =
      ((64'd1 << RSH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
   localparam longint FULL_SQ_L = longint'(FULL) * longint'(FULL);
   localparam logic [CW-1:0] FULL_SQ = CW'(FULL_SQ_L);
   localparam logic [ZW-1:0] ZMAX    = ZW'(DIVISOR) * ZW'(FULL);

   // stage valid bits and advance enables
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;
   logic [NSTAGE-1:0] en;

   for (genvar i = 0; i < NSTAGE; i++) begin : g_en
      assign en[i] = ~(rsp_stall & (&vld_ff[NSTAGE-1:i]));
   end

   assign vld_in    = (en & {vld_ff[NSTAGE-2:0], req_valid}) | (~en & vld_ff);
   assign req_stall = ~en[0];
   assign rsp_valid = vld_ff[ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // lightness travels alongside every stage up to the output
   logic [CB-1:0] lit_ff [0:ST_OUT-1];

   // stage 0: hue clamp, sector, secondary weight, chroma factor
   logic [HB-1:0]           hue_c;
   logic [6:0]              t_in;
   logic [KB-1:0]           kx_in;
   hsl2rgb_pkg::sector_type sec_in;
   logic [CB:0]             twice_l;
   logic [CB-1:0]           dist_in;
   logic [CB-1:0]           afac_in;

   always_comb begin
      hue_c = (req_item.hue > HB'(hsl2rgb_pkg::HUE_MAX)) ?
              HB'(hsl2rgb_pkg::HUE_MAX) : req_item.hue;
      // hue modulo 120
      if (hue_c >= HB'(hsl2rgb_pkg::HUE_240)) begin
         t_in = 7'(hue_c - HB'(hsl2rgb_pkg::HUE_240));
      end else if (hue_c >= HB'(hsl2rgb_pkg::HUE_120)) begin
         t_in = 7'(hue_c - HB'(hsl2rgb_pkg::HUE_120));
      end else begin
         t_in = 7'(hue_c);
      end
      kx_in = (t_in >= 7'(hsl2rgb_pkg::SECTOR_SPAN)) ?
              KB'(7'(hsl2rgb_pkg::HUE_120) - t_in) : KB'(t_in);
      // sector pick
      if (hue_c < HB'(hsl2rgb_pkg::SECTOR_SPAN)) begin
         sec_in = hsl2rgb_pkg::SECTOR_RED_YELLOW;
      end else if (hue_c < HB'(hsl2rgb_pkg::HUE_120)) begin
         sec_in = hsl2rgb_pkg::SECTOR_YELLOW_GREEN;
      end else if (hue_c < HB'(hsl2rgb_pkg::HUE_180)) begin
         sec_in = hsl2rgb_pkg::SECTOR_GREEN_CYAN;
      end else if (hue_c < HB'(hsl2rgb_pkg::HUE_240)) begin
         sec_in = hsl2rgb_pkg::SECTOR_CYAN_BLUE;
      end else if (hue_c < HB'(hsl2rgb_pkg::HUE_300)) begin
         sec_in = hsl2rgb_pkg::SECTOR_BLUE_MAGENTA;
      end else begin
         sec_in = hsl2rgb_pkg::SECTOR_MAGENTA_RED;
      end
      // 1 - |2L - 1|, scaled by full scale
      twice_l = {req_item.lightness, 1'b0};
      dist_in = (twice_l >= (CB+1)'(FULL)) ? CB'(twice_l - (CB+1)'(FULL)) :
                CB'((CB+1)'(FULL) - twice_l);
      afac_in = CB'(FULL) - dist_in;
   end

   logic [CB-1:0]           afac0_ff;
   logic [CB-1:0]           sat0_ff;
   logic [KB-1:0]           kx0_ff;
   hsl2rgb_pkg::sector_type sec0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         afac0_ff  <= afac_in;
         sat0_ff   <= req_item.saturation;
         kx0_ff    <= kx_in;
         sec0_ff   <= sec_in;
         lit_ff[0] <= req_item.lightness;
      end
   end

   // stage 1: chroma, scaled by full scale squared
   logic [CW-1:0]           cn_in;
   logic [CW-1:0]           cn1_ff;
   logic [KB-1:0]           kx1_ff;
   hsl2rgb_pkg::sector_type sec1_ff;

   assign cn_in = CW'(afac0_ff) * CW'(sat0_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         cn1_ff    <= cn_in;
         kx1_ff    <= kx0_ff;
         sec1_ff   <= sec0_ff;
         lit_ff[1] <= lit_ff[0];
      end
   end

   // stage 2: per-channel weight times chroma, plus the shared offset term
   logic [KB-1:0] wgt_in  [0:2];
   logic [ZW-1:0] prod_in [0:2];
   logic [ZW-1:0] base_in;
   logic [ZW-1:0] prod2_ff [0:2];
   logic [ZW-1:0] base2_ff;

   always_comb begin
      case (sec1_ff)
         hsl2rgb_pkg::SECTOR_RED_YELLOW: begin
            wgt_in[0] = KB'(hsl2rgb_pkg::SECTOR_SPAN);
            wgt_in[1] = kx1_ff;
            wgt_in[2] = '0;
         end
         hsl2rgb_pkg::SECTOR_YELLOW_GREEN: begin
            wgt_in[0] = kx1_ff;
            wgt_in[1] = KB'(hsl2rgb_pkg::SECTOR_SPAN);
            wgt_in[2] = '0;
         end
         hsl2rgb_pkg::SECTOR_GREEN_CYAN: begin
            wgt_in[0] = '0;
            wgt_in[1] = KB'(hsl2rgb_pkg::SECTOR_SPAN);
            wgt_in[2] = kx1_ff;
         end
         hsl2rgb_pkg::SECTOR_CYAN_BLUE: begin
            wgt_in[0] = '0;
            wgt_in[1] = kx1_ff;
            wgt_in[2] = KB'(hsl2rgb_pkg::SECTOR_SPAN);
         end
         hsl2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
            wgt_in[0] = kx1_ff;
            wgt_in[1] = '0;
            wgt_in[2] = KB'(hsl2rgb_pkg::SECTOR_SPAN);
         end
         hsl2rgb_pkg::SECTOR_MAGENTA_RED: begin
            wgt_in[0] = KB'(hsl2rgb_pkg::SECTOR_SPAN);
            wgt_in[1] = '0;
            wgt_in[2] = kx1_ff;
         end
         default: begin
            wgt_in[0] = '0;
            wgt_in[1] = '0;
            wgt_in[2] = '0;
         end
      endcase
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = ZW'(wgt_in[c]) * ZW'(cn1_ff);
      end
      base_in = ZW'(FULL_SQ - cn1_ff) * ZW'(hsl2rgb_pkg::HALF_SPAN);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         prod2_ff  <= prod_in;
         base2_ff  <= base_in;
         lit_ff[2] <= lit_ff[1];
      end
   end

   // stage 3: biased channel sum, always within 0 .. 60*full^2
   logic [ZW-1:0] zsum_in [0:2];
   logic [ZW-1:0] zsum_ff [0:2];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         zsum_in[c] = prod2_ff[c] + base2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_ZSUM]) begin
         zsum_ff         <= zsum_in;
         lit_ff[ST_ZSUM] <= lit_ff[ST_ZSUM-1];
      end
   end

   // stage 4: quotient by 60*full through the reciprocal, exact over the sum range
   logic [PW-1:0] qprod_in [0:2];
   logic [CB-1:0] quo_in   [0:2];
   logic [CB-1:0] quo_ff   [0:2];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         qprod_in[c] = PW'(zsum_ff[c]) * PW'(RECIP);
         quo_in[c]   = qprod_in[c][RSH +: CB];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_QUO]) begin
         quo_ff         <= quo_in;
         lit_ff[ST_QUO] <= lit_ff[ST_QUO-1];
      end
   end

   // output stage: add lightness, remove the bias, clamp to the channel range
   logic signed [CB+1:0] tot_in [0:2];
   logic [CB-1:0]        chan_in [0:2];
   hsl2rgb_pkg::hsl_rsp_type rsp_ff;
   hsl2rgb_pkg::hsl_rsp_type rsp_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         tot_in[c] = $signed({2'b00, lit_ff[ST_OUT-1]}) + $signed({2'b00, quo_ff[c]})
                     - $signed((CB+2)'(OFFSET));
         if (tot_in[c] < 0) begin
            chan_in[c] = '0;
         end else if (tot_in[c] > $signed((CB+2)'(FULL))) begin
            chan_in[c] = CB'(FULL);
         end else begin
            chan_in[c] = tot_in[c][CB-1:0];
         end
      end
      rsp_in.red   = chan_in[0];
      rsp_in.green = chan_in[1];
      rsp_in.blue  = chan_in[2];
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item = rsp_ff;

   // checks
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_stall && (&vld_ff)))
      else $error("input stalled while the pipeline has a free stage");

   a_sum_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_ZSUM] |-> (zsum_ff[0] <= ZMAX && zsum_ff[1] <= ZMAX &&
                           zsum_ff[2] <= ZMAX))
      else $error("channel sum beyond reciprocal range");

   a_item_advances: assert property (@(posedge clock) disable iff (reset)
      (!rsp_stall && vld_ff[ST_OUT-1]) |=> rsp_valid)
      else $error("item lost on its way to the output register");

endmodule

`default_nettype wire

### tb/tb_hsl_to_rgb_converter_unit.sv
`timescale 1ns / 100ps

module tb_hsl_to_rgb_converter_unit;
   import hsl2rgb_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD    = 150;
   localparam longint unsigned FULL  = FULL_SCALE;
   localparam longint unsigned DENOM = FULL * FULL * HUE_120;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   hsl_req_type req_item  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   hsl_rsp_type rsp_item;

   // colours still owed by the block, oldest first
   hsl_rsp_type expected_rgb[$];
   int          mismatch_count  = 0;
   int          quiet_cycles    = 0;
   bit          sender_idles    = 1'b1;
   bit          receiver_stalls = 1'b1;
   int          hold_request    = 0;

   hsl_to_rgb_converter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // scale an exact sum over DENOM to a channel code, round half up, clamp
   function automatic logic [CHANNEL_BITS-1:0] round_channel(longint unsigned num);
      longint unsigned code;
      code = (num * FULL + DENOM / 2) / DENOM;
      if (code > FULL) code = FULL;
      return code[CHANNEL_BITS-1:0];
   endfunction

   // exact rational hsl to rgb over the common denominator
   function automatic hsl_rsp_type predict_rgb(hsl_req_type px);
      longint unsigned hue, sat, light, twice_l, l_span, chroma, phase, kx;
      longint unsigned c_num, x_num, m_base, m_sub, m_num, r, g, b;
      sector_type      sector;
      hsl_rsp_type     rgb;
      hue   = px.hue;
      sat   = px.saturation;
      light = px.lightness;
      if (hue > HUE_MAX) hue = HUE_MAX;
      // chroma carries FULL^2, from the distance of 2L to full scale
      twice_l = 2 * light;
      l_span  = (twice_l >= FULL) ? twice_l - FULL : FULL - twice_l;
      chroma  = (FULL - l_span) * sat;
      // secondary weight kx/60 from the position within a 120-degree span
      phase  = hue % HUE_120;
      kx     = (phase >= SECTOR_SPAN) ? HUE_120 - phase : phase;
      c_num  = chroma * HUE_120;
      x_num  = chroma * kx * 2;
      m_base = light * FULL * HUE_120;
      m_sub  = chroma * SECTOR_SPAN;
      m_num  = (m_base >= m_sub) ? m_base - m_sub : 0;
      sector = sector_type'(3'(hue / SECTOR_SPAN));
      case (sector)
         SECTOR_RED_YELLOW: begin
            r = c_num; g = x_num; b = 0;
         end
         SECTOR_YELLOW_GREEN: begin
            r = x_num; g = c_num; b = 0;
         end
         SECTOR_GREEN_CYAN: begin
            r = 0; g = c_num; b = x_num;
         end
         SECTOR_CYAN_BLUE: begin
            r = 0; g = x_num; b = c_num;
         end
         SECTOR_BLUE_MAGENTA: begin
            r = x_num; g = 0; b = c_num;
         end
         default: begin
            r = c_num; g = 0; b = x_num;
         end
      endcase
      rgb.red   = round_channel(r + m_num);
      rgb.green = round_channel(g + m_num);
      rgb.blue  = round_channel(b + m_num);
      return rgb;
   endfunction

   function automatic hsl_req_type make_pixel(int unsigned hue, int unsigned sat,
                                              int unsigned light);
      hsl_req_type px;
      px.hue        = hue[HUE_BITS-1:0];
      px.saturation = sat[CHANNEL_BITS-1:0];
      px.lightness  = light[CHANNEL_BITS-1:0];
      return px;
   endfunction

   // fractions lean on the ends and the midpoint now and then
   function automatic int unsigned random_fraction();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      case (pick)
         0: return 0;
         1: return FULL_SCALE;
         2: return FULL_SCALE / 2;
         3: return FULL_SCALE / 2 + 1;
         default: return $urandom_range(0, FULL_SCALE);
      endcase
   endfunction

   function automatic hsl_req_type random_pixel();
      int unsigned pick, hue;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         // out-of-range hue, clamped by the block
         hue = $urandom_range(HUE_MAX + 1, (1 << HUE_BITS) - 1);
      end else if (pick == 1) begin
         // first or last degree of a sector
         hue = SECTOR_SPAN * $urandom_range(0, 5);
         if ($urandom_range(0, 1)) hue = hue + SECTOR_SPAN - 1;
      end else begin
         hue = $urandom_range(0, HUE_MAX);
      end
      return make_pixel(hue, random_fraction(), random_fraction());
   endfunction

   // offer one item, after a random gap if sender_idles is set, and hold it until taken
   task automatic send_pixel(input hsl_req_type px);
      int gap;
      gap = sender_idles ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rgb.push_back(predict_rgb(px));
   endtask

   // stop offering and wait for every owed colour
   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_rgb.size() != 0);
   endtask

   task automatic report_field(input string name, input logic [CHANNEL_BITS-1:0] want,
                               input logic [CHANNEL_BITS-1:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
   endtask

   // sector edges, clamped hue, greys, black, white, the lightness midpoint
   task automatic test_directed_corners();
      int unsigned hue_edges[12] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359};
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      foreach (hue_edges[i]) send_pixel(make_pixel(hue_edges[i], FULL_SCALE, 128));
      send_pixel(make_pixel(HUE_MAX + 1, FULL_SCALE, 128));
      send_pixel(make_pixel((1 << HUE_BITS) - 1, FULL_SCALE, 128));
      send_pixel(make_pixel((1 << HUE_BITS) - 1, FULL_SCALE, FULL_SCALE));
      send_pixel(make_pixel(200, 0, 100));
      send_pixel(make_pixel(0, 0, 0));
      send_pixel(make_pixel(90, FULL_SCALE, 0));
      send_pixel(make_pixel(270, FULL_SCALE, FULL_SCALE));
      send_pixel(make_pixel(30, FULL_SCALE, 127));
      send_pixel(make_pixel(210, 1, 1));
      send_pixel(make_pixel(330, 200, 64));
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count, input bit idles, input bit stalls);
      sender_idles    = idles;
      receiver_stalls = stalls;
      repeat (count) send_pixel(random_pixel());
   endtask

   // long output hold while items keep coming, so the input backs up
   task automatic test_output_backpressure();
      sender_idles    = 1'b0;
      receiver_stalls = 1'b1;
      hold_request    = LONG_HOLD;
      repeat (100) send_pixel(random_pixel());
      wait_drained();
   endtask

   // bursts with the sender waiting for a full drain between them
   task automatic test_drain_pause();
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      repeat (6) begin
         repeat (20) send_pixel(random_pixel());
         wait_drained();
      end
   endtask

   // receiver: random stall before each item if receiver_stalls is set, long hold on request
   initial begin : rgb_receiver
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = receiver_stalls ? $urandom_range(0, 7) : 0;
         if (hold_request > 0) begin
            hold         = hold_request;
            hold_request = 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // compare each accepted colour with the oldest owed one
   always @(posedge clock) begin : rgb_checker
      hsl_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rgb.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected item, expected none, got %p", $time, rsp_item);
         end else begin
            want = expected_rgb.pop_front();
            if (rsp_item.red !== want.red) report_field("red", want.red, rsp_item.red);
            if (rsp_item.green !== want.green)
               report_field("green", want.green, rsp_item.green);
            if (rsp_item.blue !== want.blue) report_field("blue", want.blue, rsp_item.blue);
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("%0t: timeout, no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // test sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_traffic(700, 1'b1, 1'b1);
      test_random_traffic(300, 1'b0, 1'b0);
      test_output_backpressure();
      test_random_traffic(250, 1'b1, 1'b0);
      test_random_traffic(250, 1'b0, 1'b1);
      test_drain_pause();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
